// ----- hw/rtl/xbr_pkg.sv -----
// Package: shared types and constants for the xoshiro bounded random block.
`timescale 1ns / 1ps
`default_nettype none

package xbr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned PROB_W = 25;
    localparam int unsigned VALUE_W = 33;

    // splitmix32 constants
    localparam logic [WORD_W-1:0] SEED_STEP = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] MIX_ONE = 32'h21F0_AAAD;
    localparam logic [WORD_W-1:0] MIX_TWO = 32'h735A_2D97;

    // 1.0 in 1.24 fixed point
    localparam logic [PROB_W-1:0] PROB_ONE = 25'h100_0000;

    typedef enum logic [1:0] {
        FUNC_RAW    = 2'd0,
        FUNC_BELOW  = 2'd1,
        FUNC_RANGE  = 2'd2,
        FUNC_CHANCE = 2'd3
    } func_t;

    // datapath operation issued by the controller each cycle
    typedef enum logic [3:0] {
        DP_NONE,
        DP_SEED_LOAD,
        DP_MIX1,
        DP_MIX2,
        DP_STORE,
        DP_ACCEPT,
        DP_DRAW,
        DP_MUL,
        DP_DIV_START,
        DP_DIV_STEP,
        DP_OUTPUT
    } dp_op_t;

    typedef struct packed {
        logic in_bounded;  // incoming beat is a bounded or range request
        logic in_n_zero;   // incoming beat has bound or span of zero
        logic bounded;     // held request needs the multiply/reject path
        logic low_ge_n;    // low product word >= n, accept at once
        logic low_lt_thr;  // low product word below rejection threshold
        logic div_last;    // final remainder step this cycle
        logic seed_last;   // storing the last state word
    } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/xbr_datapath.sv -----
// Datapath: generator state, seeding mixer, shared multiplier, remainder unit, output register.
`timescale 1ns / 1ps
`default_nettype none

module xbr_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire xbr_pkg::dp_op_t              op,
    output xbr_pkg::stat_t                    stat,
    input  wire logic [63:0]                  seed,
    input  wire logic [1:0]                   func,
    input  wire logic [31:0]                  bound,
    input  wire logic signed [31:0]           range_low,
    input  wire logic signed [31:0]           range_high,
    input  wire logic [xbr_pkg::PROB_W-1:0]   probability,
    output logic signed [xbr_pkg::VALUE_W-1:0] value,
    output logic                              hit
);

    logic [31:0] gen_reg [4];
    logic [31:0] ctr_reg;
    logic [1:0]  idx_reg;
    logic [31:0] draw_reg;
    logic [31:0] n_reg;
    logic [31:0] lo_reg;
    logic [xbr_pkg::PROB_W-1:0] prob_reg;
    xbr_pkg::func_t func_reg;
    logic [63:0] prod_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [4:0]  cnt_reg;
    logic signed [xbr_pkg::VALUE_W-1:0] value_reg;
    logic        hit_reg;

    xbr_pkg::func_t in_func;
    logic [31:0] span_in;
    logic [31:0] n_in;
    logic [31:0] ctr_step;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [31:0] mix_z;
    logic [31:0] x5;
    logic [31:0] rot7;
    logic [31:0] draw_val;
    logic [31:0] s2a;
    logic [31:0] s3a;
    logic [32:0] shifted;
    logic [31:0] below_val;
    logic [31:0] range_val;
    logic [xbr_pkg::PROB_W-1:0] frac;
    logic signed [xbr_pkg::VALUE_W-1:0] value_next;
    logic        hit_next;

    assign in_func  = xbr_pkg::func_t'(func);
    assign span_in  = $unsigned(range_high) - $unsigned(range_low) + 32'd1;
    assign n_in     = (in_func == xbr_pkg::FUNC_RANGE) ? span_in : bound;
    assign ctr_step = ctr_reg + xbr_pkg::SEED_STEP;
    assign mix_z    = prod_reg[31:0] ^ (prod_reg[31:0] >> 15);

    // one shared 32x32 multiplier
    always_comb
    begin
        unique case (op)
            xbr_pkg::DP_MIX1:
            begin
                mul_a = ctr_step ^ (ctr_step >> 16);
                mul_b = xbr_pkg::MIX_ONE;
            end
            xbr_pkg::DP_MIX2:
            begin
                mul_a = mix_z;
                mul_b = xbr_pkg::MIX_TWO;
            end
            default:
            begin
                mul_a = draw_reg;
                mul_b = n_reg;
            end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    // xoshiro128** scrambler: rotl(s1 * 5, 7) * 9 as shift-adds
    assign x5       = gen_reg[1] + (gen_reg[1] << 2);
    assign rot7     = {x5[24:0], x5[31:25]};
    assign draw_val = rot7 + (rot7 << 3);
    assign s2a      = gen_reg[2] ^ gen_reg[0];
    assign s3a      = gen_reg[3] ^ gen_reg[1];

    // restoring remainder step
    assign shifted = {rem_reg, dvd_reg[31]};

    assign below_val = (n_reg == 32'd0) ? 32'd0 : prod_reg[63:32];
    assign range_val = lo_reg + below_val;
    assign frac      = {1'b0, draw_reg[31:8]};

    always_comb
    begin
        value_next = '0;
        hit_next   = 1'b0;
        unique case (func_reg)
            xbr_pkg::FUNC_RAW:    value_next = $signed({1'b0, draw_reg});
            xbr_pkg::FUNC_BELOW:  value_next = $signed({1'b0, below_val});
            xbr_pkg::FUNC_RANGE:  value_next = $signed({range_val[31], range_val});
            xbr_pkg::FUNC_CHANCE: hit_next = (frac < prob_reg);
        endcase
    end

    // seeding control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            unique case (op)
                xbr_pkg::DP_SEED_LOAD:
                begin
                    ctr_reg <= seed[31:0] ^ seed[63:32];
                    idx_reg <= '0;
                end
                xbr_pkg::DP_MIX1:  ctr_reg <= ctr_step;
                xbr_pkg::DP_STORE: idx_reg <= idx_reg + 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            xbr_pkg::DP_MIX1, xbr_pkg::DP_MIX2, xbr_pkg::DP_MUL:
                prod_reg <= prod;
            xbr_pkg::DP_STORE:
                gen_reg[idx_reg] <= mix_z;
            xbr_pkg::DP_ACCEPT:
            begin
                func_reg <= in_func;
                n_reg    <= n_in;
                lo_reg   <= $unsigned(range_low);
                prob_reg <= (probability > xbr_pkg::PROB_ONE) ? xbr_pkg::PROB_ONE
                                                              : probability;
            end
            xbr_pkg::DP_DRAW:
            begin
                draw_reg   <= draw_val;
                gen_reg[0] <= gen_reg[0] ^ s3a;
                gen_reg[1] <= gen_reg[1] ^ s2a;
                gen_reg[2] <= s2a ^ (gen_reg[1] << 9);
                gen_reg[3] <= {s3a[20:0], s3a[31:21]};
            end
            xbr_pkg::DP_DIV_START:
            begin
                rem_reg <= '0;
                dvd_reg <= 32'd0 - n_reg;
                cnt_reg <= '0;
            end
            xbr_pkg::DP_DIV_STEP:
            begin
                rem_reg <= (shifted >= {1'b0, n_reg}) ? 32'(shifted - {1'b0, n_reg})
                                                      : shifted[31:0];
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
            end
            xbr_pkg::DP_OUTPUT:
            begin
                value_reg <= value_next;
                hit_reg   <= hit_next;
            end
            default: ;
        endcase
    end

    assign stat.in_bounded = (in_func == xbr_pkg::FUNC_BELOW) || (in_func == xbr_pkg::FUNC_RANGE);
    assign stat.in_n_zero  = (n_in == 32'd0);
    assign stat.bounded    = (func_reg == xbr_pkg::FUNC_BELOW) || (func_reg == xbr_pkg::FUNC_RANGE);
    assign stat.low_ge_n   = (prod_reg[31:0] >= n_reg);
    assign stat.low_lt_thr = (prod_reg[31:0] < rem_reg);
    assign stat.div_last   = (cnt_reg == 5'd31);
    assign stat.seed_last  = (idx_reg == 2'd3);

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/xbr_ctrl.sv -----
// Controller: sequences seeding, draws, rejection checks and the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module xbr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire xbr_pkg::stat_t stat,
    output xbr_pkg::dp_op_t     op
);

    typedef enum logic [3:0] {
        ST_MIX1,
        ST_MIX2,
        ST_STORE,
        ST_IDLE,
        ST_DRAW,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   thr_known_reg;
    logic   thr_known_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        thr_known_next = thr_known_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op             = xbr_pkg::DP_NONE;
        unique case (state_reg)
            ST_MIX1:
            begin
                op         = xbr_pkg::DP_MIX1;
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                op         = xbr_pkg::DP_MIX2;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                op         = xbr_pkg::DP_STORE;
                state_next = stat.seed_last ? ST_IDLE : ST_MIX1;
            end
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    op         = xbr_pkg::DP_SEED_LOAD;
                    state_next = ST_MIX1;
                end
                else if (in_valid)
                begin
                    op             = xbr_pkg::DP_ACCEPT;
                    thr_known_next = 1'b0;
                    state_next     = (stat.in_bounded && stat.in_n_zero) ? ST_DONE : ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                op         = xbr_pkg::DP_DRAW;
                state_next = stat.bounded ? ST_MUL : ST_DONE;
            end
            ST_MUL:
            begin
                op         = xbr_pkg::DP_MUL;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (stat.low_ge_n)
                    state_next = ST_DONE;
                else if (thr_known_reg)
                    state_next = stat.low_lt_thr ? ST_DRAW : ST_DONE;
                else
                begin
                    op         = xbr_pkg::DP_DIV_START;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                op = xbr_pkg::DP_DIV_STEP;
                if (stat.div_last)
                begin
                    thr_known_next = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op             = xbr_pkg::DP_OUTPUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_MIX1;  // expand seed zero after reset
            thr_known_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_known_reg <= thr_known_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/xoshiro_bounded_random_top.sv -----
// Top level: xoshiro128** generator with raw, bounded, range and chance requests.
`timescale 1ns / 1ps
`default_nettype none
// out_valid rises after a request is drawn (raw, chance), drawn, multiplied and checked
// (bounded, range), or at once (zero bound or span); a low product below n adds a
// remainder pass once per request, and each rejected draw repeats the draw, multiply
// and check steps. One request at a time; a result held by out_ready stalls the next
// request. Reset: seed zero expands into four state words, each by a mix, a second mix
// and a store; a seed write repeats that pass. No request beats are taken during it.

module xoshiro_bounded_random_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // seed write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [63:0]                   seed,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    func,
    input  wire logic [31:0]                   bound,
    input  wire logic signed [31:0]            range_low,
    input  wire logic signed [31:0]            range_high,
    input  wire logic [xbr_pkg::PROB_W-1:0]    probability,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [xbr_pkg::VALUE_W-1:0] value,
    output logic                               hit
);

    // controller drives one datapath op per cycle and sees a status bundle
    xbr_pkg::dp_op_t op;
    xbr_pkg::stat_t  stat;

    xbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .op        (op)
    );

    // state words, splitmix mixer, shared multiplier, rejection threshold unit;
    // the result beat is held in the datapath output register
    xbr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .stat        (stat),
        .seed        (seed),
        .func        (func),
        .bound       (bound),
        .range_low   (range_low),
        .range_high  (range_high),
        .probability (probability),
        .value       (value),
        .hit         (hit)
    );

endmodule

`default_nettype wire
